@@ rtl/cwa_pkg.sv @@
// Shared types and constants of the centered window average block.
package cwa_pkg;

  localparam int SAMPLE_W = 17;
  localparam int AVG_W    = 18;
  localparam int SUM_W    = 24;
  localparam int SEEN_W   = 8;
  localparam int RADIUS_W = 6;
  localparam int WIN_W    = RADIUS_W + 1;
  localparam int CNT_W    = RADIUS_W + 1;
  localparam int ADDR_W   = 3;
  localparam int DATA_W   = 32;

  localparam logic [SEEN_W-1:0] SEEN_MAX = '1;
  localparam logic [AVG_W-1:0]  AVG_NONE = '1;

  // Register byte addresses
  localparam logic [ADDR_W-1:0] REG_RADIUS = 3'd0;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                last;
  } cwa_in_t;

  typedef struct packed {
    logic signed [AVG_W-1:0] average;
    logic                    is_final;
  } cwa_out_t;

endpackage

@@ rtl/cwa_ring.sv @@
// Sample ring: one write port, one read port, registered read data.
module cwa_ring
  import cwa_pkg::*;
#(
  parameter int Depth = 128,
  localparam int AW   = $clog2(Depth)
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AW-1:0]       waddr_i,
  input  logic [SAMPLE_W-1:0] wdata_i,
  input  logic [AW-1:0]       raddr_i,
  output logic [SAMPLE_W-1:0] rdata_o
);

  logic [SAMPLE_W-1:0] mem [Depth];
  logic [SAMPLE_W-1:0] rdata_q;

  // Write the new sample, read the oldest one
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/cwa_div.sv @@
// Restoring divider: one quotient bit per cycle of the window sum by the window width.
module cwa_div
  import cwa_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [SUM_W-1:0] dividend_i,
  input  logic [WIN_W-1:0] divisor_i,
  output logic             done_o,
  output logic [SUM_W-1:0] quotient_o
);

  localparam int CW = $clog2(SUM_W);
  localparam logic [CW-1:0] LAST_STEP = CW'(SUM_W - 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [SUM_W-1:0] quo_q, quo_d;
  logic [WIN_W-1:0] rem_q, rem_d;
  logic [WIN_W-1:0] dvs_q, dvs_d;
  logic [WIN_W:0]   rem_sh;
  logic [WIN_W:0]   rem_sub;
  logic             fits;

  // Shift in the next dividend bit and trial-subtract
  assign rem_sh  = {rem_q, quo_q[SUM_W-1]};
  assign fits    = rem_sh >= {1'b0, dvs_q};
  assign rem_sub = rem_sh - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[SUM_W-2:0], fits};
      rem_d = fits ? rem_sub[WIN_W-1:0] : rem_sh[WIN_W-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LAST_STEP) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Hold control state under reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

@@ rtl/centered_window_average_top.sv @@
// Top level of the centered window average block: control, sum update and config port.
// An item that closes a full window raises its first result after the sum update, the
// bit-serial divider, the done flag and the output register. Other items raise their
// first result straight after the sum update, or none.
// One item at a time: the next item is taken the cycle after its last result is delivered.
// Reset clears control, sum, counters and radius; the ring holds garbage until written.
module centered_window_average_top
  import cwa_pkg::*;
#(
  parameter int MAX_RADIUS = 63,
  parameter int RING_DEPTH = 128
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // Sample channel
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  cwa_in_t           in_i,
  // Result channel
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output cwa_out_t          out_o,
  // Configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam int AW     = $clog2(RING_DEPTH);
  localparam int PW     = AW + 2;
  localparam int HALF   = (RING_DEPTH - 1) / 2;
  localparam int RCLAMP = (MAX_RADIUS < HALF) ? MAX_RADIUS : HALF;
  localparam logic [RADIUS_W-1:0] R_LIMIT = RADIUS_W'(RCLAMP);
  localparam logic [PW-1:0]       DEPTH_P = PW'(RING_DEPTH);
  localparam logic [AW-1:0]       WP_LAST = AW'(RING_DEPTH - 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_DIV  = 4'b0100,
    S_OUT  = 4'b1000
  } state_e;

  state_e              state_q, state_d;
  logic [SAMPLE_W-1:0] sample_q, sample_d;
  logic                last_q, last_d;
  logic [SUM_W-1:0]    sum_q, sum_d;
  logic [SEEN_W-1:0]   seen_q, seen_d;
  logic [AW-1:0]       wp_q, wp_d;
  logic [RADIUS_W-1:0] radius_q, radius_d;
  logic [AVG_W-1:0]    avg_q, avg_d;
  logic [CNT_W-1:0]    left_q, left_d;

  logic [RADIUS_W-1:0] r_eff;
  logic [WIN_W-1:0]    win;
  logic [PW-1:0]       rd_sum;
  logic [PW-1:0]       rd_wrap;
  logic [AW-1:0]       rd_addr;
  logic [SAMPLE_W-1:0] old_sample;
  logic [SUM_W-1:0]    sum_add;
  logic [SUM_W-1:0]    sum_new;
  logic                full_ring;
  logic                at_center;
  logic                full_win;
  logic [CNT_W-1:0]    last_cnt;
  logic                cfg_wr;
  logic                in_acc;
  logic                out_acc;
  logic                ring_we;
  logic                div_start;
  logic                div_done;
  logic [SUM_W-1:0]    div_quo;

  // Clamp the radius and form the window width
  assign r_eff = (radius_q > R_LIMIT) ? R_LIMIT : radius_q;
  assign win   = {r_eff, 1'b1};

  // Oldest slot: write pointer minus window width, modulo the depth
  assign rd_sum  = PW'(wp_q) + DEPTH_P - PW'(win);
  assign rd_wrap = (rd_sum >= DEPTH_P) ? (rd_sum - DEPTH_P) : rd_sum;
  assign rd_addr = rd_wrap[AW-1:0];

  cwa_ring #(
    .Depth(RING_DEPTH)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (ring_we),
    .waddr_i(wp_q),
    .wdata_i(sample_q),
    .raddr_i(rd_addr),
    .rdata_o(old_sample)
  );

  // Update the running sum and classify the position
  assign full_ring = seen_q >= {1'b0, win};
  assign at_center = seen_q >= {2'b00, r_eff};
  assign full_win  = seen_q >= {1'b0, r_eff, 1'b0};
  assign sum_add   = sum_q + SUM_W'(sample_q);
  assign sum_new   = full_ring ? (sum_add - SUM_W'(old_sample)) : sum_add;
  assign last_cnt  = at_center ? ({1'b0, r_eff} + 1'b1)
                               : ({1'b0, seen_q[RADIUS_W-1:0]} + 1'b1);

  cwa_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(sum_new),
    .divisor_i (win),
    .done_o    (div_done),
    .quotient_o(div_quo)
  );

  // Handshakes
  assign cfg_wr  = psel && penable && pwrite && pready && (paddr == REG_RADIUS);
  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign out_o.average  = avg_q;
  assign out_o.is_final = last_q && (left_q == CNT_W'(1));

  assign pready = 1'b1;
  assign prdata = (paddr == REG_RADIUS) ? DATA_W'(radius_q) : '0;

  // Sequence control
  always_comb begin
    state_d   = state_q;
    sample_d  = sample_q;
    last_d    = last_q;
    sum_d     = sum_q;
    seen_d    = seen_q;
    wp_d      = wp_q;
    radius_d  = radius_q;
    avg_d     = avg_q;
    left_d    = left_q;
    ring_we   = 1'b0;
    div_start = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          sample_d = in_i.sample;
          last_d   = in_i.last;
          state_d  = S_READ;
        end
      end
      S_READ: begin
        ring_we = 1'b1;
        sum_d   = sum_new;
        wp_d    = (wp_q == WP_LAST) ? '0 : wp_q + 1'b1;
        if (seen_q != SEEN_MAX) begin
          seen_d = seen_q + 1'b1;
        end
        avg_d  = AVG_NONE;
        left_d = last_q ? last_cnt : CNT_W'(at_center);
        if (!last_q && !at_center) begin
          state_d = S_IDLE;
        end else if (full_win) begin
          div_start = 1'b1;
          state_d   = S_DIV;
        end else begin
          state_d = S_OUT;
        end
      end
      S_DIV: begin
        if (div_done) begin
          avg_d   = div_quo[AVG_W-1:0];
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_acc) begin
          avg_d  = AVG_NONE;
          left_d = left_q - 1'b1;
          if (left_q == CNT_W'(1)) begin
            state_d = S_IDLE;
            if (last_q) begin
              sum_d  = '0;
              seen_d = '0;
              wp_d   = '0;
            end
          end
        end
      end
      default: state_d = S_IDLE;
    endcase

    // Radius write restarts the sequence
    if (cfg_wr) begin
      radius_d = pwdata[RADIUS_W-1:0];
      sum_d    = '0;
      seen_d   = '0;
      wp_d     = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      sum_q    <= '0;
      seen_q   <= '0;
      wp_q     <= '0;
      radius_q <= '0;
      left_q   <= '0;
      last_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      sum_q    <= sum_d;
      seen_q   <= seen_d;
      wp_q     <= wp_d;
      radius_q <= radius_d;
      left_q   <= left_d;
      last_q   <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sample_q <= sample_d;
    avg_q    <= avg_d;
  end

endmodule
